@@ src/integer_operator_alu_macros.svh @@
// Assertion macros for the design file that checks its own logic.
`ifndef INTEGER_OPERATOR_ALU_MACROS_SVH
`define INTEGER_OPERATOR_ALU_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IOA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IOA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/ioa_pkg.sv @@
package ioa_pkg;

    localparam int unsigned DataWidth = 32;
    localparam int unsigned DivSteps  = 32;
    localparam int unsigned SqrtSteps = 16;

    typedef enum logic [4:0] {
        OP_ADD      = 5'd0,
        OP_SUB      = 5'd1,
        OP_DIV      = 5'd2,
        OP_MOD      = 5'd3,
        OP_MUL      = 5'd4,
        OP_OR       = 5'd5,
        OP_XOR      = 5'd6,
        OP_AND      = 5'd7,
        OP_HIGHMUL  = 5'd8,
        OP_SHL      = 5'd9,
        OP_SHR      = 5'd10,
        OP_SAR      = 5'd11,
        OP_ROTL     = 5'd12,
        OP_ROTR     = 5'd13,
        OP_LT       = 5'd14,
        OP_GT       = 5'd15,
        OP_LE       = 5'd16,
        OP_GE       = 5'd17,
        OP_NE       = 5'd18,
        OP_EQ       = 5'd19,
        OP_NEG      = 5'd20,
        OP_NOT      = 5'd21,
        OP_ABS      = 5'd22,
        OP_SQRT     = 5'd23,
        OP_DECODE   = 5'd24,
        OP_ENCODE   = 5'd25,
        OP_LIMITMIN = 5'd26,
        OP_LIMITMAX = 5'd27,
        OP_REV      = 5'd28
    } op_t;

    // One beat as it moves through the divide and square root steps.
    typedef struct packed {
        logic        valid;
        logic [4:0]  func;
        logic        known;
        logic [31:0] simple;
        logic        neg_q;
        logic        neg_r;
        logic        div_zero;
        logic [31:0] divisor;
        logic [31:0] rem;
        logic [31:0] dq;
        logic [17:0] sq_rem;
        logic [15:0] sq_root;
        logic [31:0] sq_src;
    } pipe_t;

    function automatic logic [31:0] bit_reverse(input logic [31:0] v);
        logic [31:0] t;
        t = ((v & 32'haaaaaaaa) >> 1) | ((v & 32'h55555555) << 1);
        t = ((t & 32'hcccccccc) >> 2) | ((t & 32'h33333333) << 2);
        t = ((t & 32'hf0f0f0f0) >> 4) | ((t & 32'h0f0f0f0f) << 4);
        t = ((t & 32'hff00ff00) >> 8) | ((t & 32'h00ff00ff) << 8);
        return {t[15:0], t[31:16]};
    endfunction

    // Position of the highest set bit plus one; zero for a zero word.
    function automatic logic [5:0] encode(input logic [31:0] v);
        logic [5:0] n;
        n = 6'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (v[i])
            begin
                n = 6'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

@@ src/ioa_if.sv @@
interface ioa_req_if;
    logic        valid;
    logic        ready;
    logic [4:0]  func;
    logic signed [31:0] left_operand;
    logic signed [31:0] right_operand;

    modport source (output valid, output func, output left_operand,
                    output right_operand, input ready);
    modport sink   (input valid, input func, input left_operand,
                    input right_operand, output ready);
endinterface

interface ioa_rsp_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] result_value;
    logic        op_valid;

    modport source (output valid, output result_value, output op_valid, input ready);
    modport sink   (input valid, input result_value, input op_valid, output ready);
endinterface

@@ src/ioa_step.sv @@
// One restoring-divide step and, in the first stages, one square root digit.
module ioa_step #(
    parameter bit SqrtStep = 1'b1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  ioa_pkg::pipe_t cur,
    output ioa_pkg::pipe_t stage_reg
);

    ioa_pkg::pipe_t stage_next;
    logic [32:0]    r_sh;
    logic [32:0]    diff;
    logic           qb;
    logic [19:0]    s_sh;
    logic [19:0]    trial;
    logic           s_ge;
    logic [19:0]    s_diff;

    always_comb
    begin
        stage_next = cur;
        r_sh  = {cur.rem, cur.dq[31]};
        diff  = r_sh - {1'b0, cur.divisor};
        qb    = !diff[32];
        stage_next.rem = qb ? diff[31:0] : r_sh[31:0];
        stage_next.dq  = {cur.dq[30:0], qb};

        s_sh   = {cur.sq_rem, cur.sq_src[31:30]};
        trial  = {2'b00, cur.sq_root, 2'b01};
        s_ge   = (s_sh >= trial);
        s_diff = s_sh - trial;
        if (SqrtStep)
        begin
            stage_next.sq_rem  = s_ge ? s_diff[17:0] : s_sh[17:0];
            stage_next.sq_root = {cur.sq_root[14:0], s_ge};
            stage_next.sq_src  = {cur.sq_src[29:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else if (advance)
        begin
            stage_reg <= stage_next;
        end
    end

endmodule

@@ src/integer_operator_alu.sv @@
// Channel | Dir | Payload                              | Handshake
// req     | in  | func, left_operand, right_operand    | valid/ready
// rsp     | out | result_value, op_valid               | valid/ready
//
// One beat is accepted every cycle unless the output stalls; a beat passes through the input
// register, operand preparation, 32 restoring-divide stages and the output register.
// The divide chain sets the depth; square root runs in the first 16 of those stages.
// Reset clears the valid bits and the divide-chain stages; the input and output data
// registers are not reset.
// A stalled output freezes the whole pipeline; req.ready is low only then.
`include "integer_operator_alu_macros.svh"

module integer_operator_alu (
    input logic     clk,
    input logic     rst_n,
    ioa_req_if.sink req,
    ioa_rsp_if.source rsp
);

    logic advance;

    logic        in_valid_reg;
    logic [4:0]  in_func_reg;
    logic [31:0] in_a_reg;
    logic [31:0] in_b_reg;

    ioa_pkg::pipe_t prep;
    ioa_pkg::pipe_t chain [0:ioa_pkg::DivSteps];

    logic        out_valid_reg;
    logic [31:0] out_result_reg;
    logic        out_known_reg;
    logic [31:0] out_result_next;

    assign advance   = !out_valid_reg || rsp.ready;
    assign req.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            in_func_reg <= req.func;
            in_a_reg    <= req.left_operand;
            in_b_reg    <= req.right_operand;
        end
    end

    // Operand preparation and all operators but divide, modulo and square root.
    logic signed [63:0] product;
    logic [63:0]        rot;
    logic [4:0]         sh;
    logic               lt;
    logic [31:0]        rev_full;
    logic [5:0]         rev_n;
    logic               known;
    logic [31:0]        simple;
    logic [31:0]        mag_a;
    logic [31:0]        mag_b;

    always_comb
    begin
        sh       = in_b_reg[4:0];
        product  = $signed(in_a_reg) * $signed(in_b_reg);
        lt       = $signed(in_a_reg) < $signed(in_b_reg);
        rev_full = ioa_pkg::bit_reverse(in_a_reg);
        if ($signed(in_b_reg) > 32)
        begin
            rev_n = 6'd32;
        end
        else
        begin
            rev_n = in_b_reg[5:0];
        end
        rot    = 64'd0;
        known  = 1'b1;
        simple = 32'd0;
        case (in_func_reg)
            ioa_pkg::OP_ADD:      simple = in_a_reg + in_b_reg;
            ioa_pkg::OP_SUB:      simple = in_a_reg - in_b_reg;
            ioa_pkg::OP_DIV:      simple = 32'd0;
            ioa_pkg::OP_MOD:      simple = 32'd0;
            ioa_pkg::OP_MUL:      simple = product[31:0];
            ioa_pkg::OP_OR:       simple = in_a_reg | in_b_reg;
            ioa_pkg::OP_XOR:      simple = in_a_reg ^ in_b_reg;
            ioa_pkg::OP_AND:      simple = in_a_reg & in_b_reg;
            ioa_pkg::OP_HIGHMUL:  simple = product[63:32];
            ioa_pkg::OP_SHL:      simple = in_a_reg << sh;
            ioa_pkg::OP_SHR:      simple = in_a_reg >> sh;
            ioa_pkg::OP_SAR:      simple = 32'($signed(in_a_reg) >>> sh);
            ioa_pkg::OP_ROTL:
            begin
                rot    = {in_a_reg, in_a_reg} << sh;
                simple = rot[63:32];
            end
            ioa_pkg::OP_ROTR:
            begin
                rot    = {in_a_reg, in_a_reg} >> sh;
                simple = rot[31:0];
            end
            ioa_pkg::OP_LT:       simple = {32{lt}};
            ioa_pkg::OP_GT:       simple = {32{!lt && (in_a_reg != in_b_reg)}};
            ioa_pkg::OP_LE:       simple = {32{lt || (in_a_reg == in_b_reg)}};
            ioa_pkg::OP_GE:       simple = {32{!lt}};
            ioa_pkg::OP_NE:       simple = {32{in_a_reg != in_b_reg}};
            ioa_pkg::OP_EQ:       simple = {32{in_a_reg == in_b_reg}};
            ioa_pkg::OP_NEG:      simple = 32'd0 - in_b_reg;
            ioa_pkg::OP_NOT:      simple = ~in_b_reg;
            ioa_pkg::OP_ABS:      simple = in_b_reg[31] ? 32'd0 - in_b_reg : in_b_reg;
            ioa_pkg::OP_SQRT:     simple = 32'd0;
            ioa_pkg::OP_DECODE:   simple = 32'd1 << sh;
            ioa_pkg::OP_ENCODE:   simple = {26'd0, ioa_pkg::encode(in_b_reg)};
            ioa_pkg::OP_LIMITMIN: simple = lt ? in_b_reg : in_a_reg;
            ioa_pkg::OP_LIMITMAX: simple = (!lt && (in_a_reg != in_b_reg)) ? in_b_reg : in_a_reg;
            ioa_pkg::OP_REV:
            begin
                if ($signed(in_b_reg) <= 0)
                begin
                    simple = 32'd0;
                end
                else
                begin
                    simple = rev_full >> (6'd32 - rev_n);
                end
            end
            default:
            begin
                known  = 1'b0;
                simple = 32'd0;
            end
        endcase

        mag_a = in_a_reg[31] ? 32'd0 - in_a_reg : in_a_reg;
        mag_b = in_b_reg[31] ? 32'd0 - in_b_reg : in_b_reg;

        prep.valid    = in_valid_reg;
        prep.func     = in_func_reg;
        prep.known    = known;
        prep.simple   = simple;
        prep.neg_q    = in_a_reg[31] ^ in_b_reg[31];
        prep.neg_r    = in_a_reg[31];
        prep.div_zero = (in_b_reg == 32'd0);
        prep.divisor  = mag_b;
        prep.rem      = 32'd0;
        prep.dq       = mag_a;
        prep.sq_rem   = 18'd0;
        prep.sq_root  = 16'd0;
        prep.sq_src   = in_b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain[0] <= '0;
        end
        else if (advance)
        begin
            chain[0] <= prep;
        end
    end

    for (genvar g = 0; g < ioa_pkg::DivSteps; g++)
    begin : g_step
        ioa_step #(
            .SqrtStep(g < ioa_pkg::SqrtSteps)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .cur      (chain[g]),
            .stage_reg(chain[g+1])
        );
    end

    ioa_pkg::pipe_t last;
    assign last = chain[ioa_pkg::DivSteps];

    always_comb
    begin
        case (last.func)
            ioa_pkg::OP_DIV:
                out_result_next = last.div_zero ? 32'd0 :
                                  (last.neg_q ? 32'd0 - last.dq : last.dq);
            ioa_pkg::OP_MOD:
                out_result_next = last.div_zero ? 32'd0 :
                                  (last.neg_r ? 32'd0 - last.rem : last.rem);
            ioa_pkg::OP_SQRT:
                out_result_next = {16'd0, last.sq_root};
            default:
                out_result_next = last.simple;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg <= out_result_next;
            out_known_reg  <= last.known;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_value = out_result_reg;
    assign rsp.op_valid     = out_known_reg;

    `IOA_ASSERT_IMPL(a_unknown_zero, clk, rst_n, out_valid_reg && !out_known_reg,
        out_result_reg == 32'd0, "unknown operator beat carries a nonzero result")
    `IOA_ASSERT_NEXT(a_stall_holds, clk, rst_n, !advance, $stable(last),
        "last divide stage moved during a stall")
    `IOA_ASSERT_IMPL(a_empty_ready, clk, rst_n, !out_valid_reg, req.ready,
        "input refused while output register is empty")

endmodule

@@ sim/integer_operator_alu_checker.sv @@
module integer_operator_alu_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_ready,
    input  logic [4:0]  req_func,
    input  logic [31:0] req_left,
    input  logic [31:0] req_right,
    input  logic        rsp_valid,
    input  logic        rsp_ready,
    input  logic [31:0] rsp_value,
    input  logic        rsp_known,
    output int          fail_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] value;
        logic        known;
    } alu_result_t;

    alu_result_t expected_results[$];

    function automatic logic [31:0] mirror_bits(input logic [31:0] v);
        logic [31:0] r;
        for (int i = 0; i < 32; i++)
        begin
            r[i] = v[31 - i];
        end
        return r;
    endfunction

    function automatic logic [31:0] floor_sqrt(input logic [31:0] v);
        logic [31:0] root;
        logic [63:0] trial;
        root = 0;
        for (int i = 15; i >= 0; i--)
        begin
            trial = 64'(root | (32'd1 << i));
            if (trial * trial <= 64'(v))
            begin
                root = root | (32'd1 << i);
            end
        end
        return root;
    endfunction

    function automatic alu_result_t compute_alu(input logic [4:0] f,
                                                input logic [31:0] a,
                                                input logic [31:0] b);
        alu_result_t res;
        logic signed [31:0] sa;
        logic signed [31:0] sb;
        logic signed [63:0] prod;
        logic [4:0] amt;
        logic [63:0] dbl;
        int n;
        sa = a;
        sb = b;
        amt = b[4:0];
        res.known = 1'b1;
        res.value = 32'd0;
        dbl = {a, a};
        case (f)
            ioa_pkg::OP_ADD: res.value = a + b;
            ioa_pkg::OP_SUB: res.value = a - b;
            ioa_pkg::OP_DIV:
            begin
                if (b == 0)
                    res.value = 0;
                else if (a == 32'h80000000 && b == 32'hffffffff)
                    res.value = 32'h80000000;
                else
                    res.value = sa / sb;
            end
            ioa_pkg::OP_MOD:
            begin
                if (b == 0 || (a == 32'h80000000 && b == 32'hffffffff))
                    res.value = 0;
                else
                    res.value = sa % sb;
            end
            ioa_pkg::OP_MUL: res.value = a * b;
            ioa_pkg::OP_OR: res.value = a | b;
            ioa_pkg::OP_XOR: res.value = a ^ b;
            ioa_pkg::OP_AND: res.value = a & b;
            ioa_pkg::OP_HIGHMUL:
            begin
                prod = 64'(sa) * 64'(sb);
                res.value = prod[63:32];
            end
            ioa_pkg::OP_SHL: res.value = a << amt;
            ioa_pkg::OP_SHR: res.value = a >> amt;
            ioa_pkg::OP_SAR: res.value = sa >>> amt;
            ioa_pkg::OP_ROTL: res.value = dbl[63 - amt -: 32];
            ioa_pkg::OP_ROTR: res.value = dbl[31 + amt -: 32];
            ioa_pkg::OP_LT: res.value = (sa < sb) ? '1 : '0;
            ioa_pkg::OP_GT: res.value = (sa > sb) ? '1 : '0;
            ioa_pkg::OP_LE: res.value = (sa <= sb) ? '1 : '0;
            ioa_pkg::OP_GE: res.value = (sa >= sb) ? '1 : '0;
            ioa_pkg::OP_NE: res.value = (a != b) ? '1 : '0;
            ioa_pkg::OP_EQ: res.value = (a == b) ? '1 : '0;
            ioa_pkg::OP_NEG: res.value = -b;
            ioa_pkg::OP_NOT: res.value = ~b;
            ioa_pkg::OP_ABS: res.value = b[31] ? -b : b;
            ioa_pkg::OP_SQRT: res.value = floor_sqrt(b);
            ioa_pkg::OP_DECODE: res.value = 32'd1 << amt;
            ioa_pkg::OP_ENCODE:
            begin
                for (int i = 0; i < 32; i++)
                begin
                    if (b[i])
                        res.value = i + 1;
                end
            end
            ioa_pkg::OP_LIMITMIN: res.value = (sa < sb) ? b : a;
            ioa_pkg::OP_LIMITMAX: res.value = (sa > sb) ? b : a;
            ioa_pkg::OP_REV:
            begin
                n = (sb > 32) ? 32 : sb;
                if (sb <= 0)
                    res.value = 0;
                else
                    res.value = 32'(64'(mirror_bits(a)) >> (32 - n));
            end
            default: res.known = 1'b0;
        endcase
        return res;
    endfunction

    assign pending_count = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        alu_result_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                expected_results.push_back(compute_alu(req_func, req_left, req_right));
            end
            if (rsp_valid && rsp_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat: value %h known %b",
                             $time, rsp_value, rsp_known);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.value !== rsp_value || want.known !== rsp_known)
                    begin
                        $display("%0t: mismatch: expected value %h known %b, got value %h known %b",
                                 $time, want.value, want.known, rsp_value, rsp_known);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

@@ sim/integer_operator_alu_tb.sv @@
module integer_operator_alu_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   send_idle_pct = 20;
    int   take_idle_pct = 88;
    bit   hold_off = 1'b0;
    int   fail_count;
    int   pending_count;

    ioa_req_if req ();
    ioa_rsp_if rsp ();

    always #2 clk = ~clk;

    integer_operator_alu dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    integer_operator_alu_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req.valid),
        .req_ready     (req.ready),
        .req_func      (req.func),
        .req_left      (req.left_operand),
        .req_right     (req.right_operand),
        .rsp_valid     (rsp.valid),
        .rsp_ready     (rsp.ready),
        .rsp_value     (rsp.result_value),
        .rsp_known     (rsp.op_valid),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 32'hffffffff;
            3: return 32'(int'($urandom_range(0, 40)) - 4);
            4: return 32'd1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // Puts one beat on the request channel and returns once it is taken.
    task automatic send_op(input logic [4:0] f, input logic [31:0] a, input logic [31:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid         <= 1'b1;
        req.func          <= f;
        req.left_operand  <= a;
        req.right_operand <= b;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        rsp.ready <= !hold_off && ($urandom_range(0, 99) >= take_idle_pct);
    end

    initial
    begin
        req.valid = 1'b0;
        req.func = '0;
        req.left_operand = '0;
        req.right_operand = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Directed corners: every code, extreme operands, and the special cases.
        for (int f = 0; f < 32; f++)
        begin
            send_op(5'(f), 32'h80000000, 32'hffffffff);
        end
        send_op(ioa_pkg::OP_DIV, 32'h7fffffff, 32'h0);
        send_op(ioa_pkg::OP_MOD, 32'h80000000, 32'h0);
        send_op(ioa_pkg::OP_MOD, 32'hfffffff9, 32'h2);
        send_op(ioa_pkg::OP_ROTL, 32'h12345678, 32'h0);
        send_op(ioa_pkg::OP_SHL, 32'h12345678, 32'hffffffe4);
        send_op(ioa_pkg::OP_ENCODE, 32'h0, 32'h0);
        send_op(ioa_pkg::OP_REV, 32'h0000000b, 32'h0);
        send_op(ioa_pkg::OP_REV, 32'h0000000b, 32'd4);
        send_op(ioa_pkg::OP_REV, 32'hdeadbeef, 32'd100);
        send_op(ioa_pkg::OP_SQRT, 32'h0, 32'hffffffff);
        send_op(ioa_pkg::OP_ABS, 32'h0, 32'h80000000);
        send_op(ioa_pkg::OP_HIGHMUL, 32'h7fffffff, 32'h7fffffff);
        // Long receiver hold-off so the pipeline fills and stalls its input.
        hold_off = 1'b1;
        send_idle_pct = 0;
        fork
            begin
                repeat (120) @(posedge clk);
                hold_off = 1'b0;
            end
            repeat (60) send_op(5'($urandom_range(0, 31)), pick_operand(), pick_operand());
        join
        send_idle_pct = 20;
        for (int i = 0; i < 450; i++)
        begin
            if (i == 150)
            begin
                send_idle_pct = 88;
                take_idle_pct = 20;
            end
            if (i == 300)
            begin
                send_idle_pct = 0;
                take_idle_pct = 0;
            end
            send_op(5'($urandom_range(0, 31)), pick_operand(),
                    ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 40)) : pick_operand());
        end
        req.valid <= 1'b0;
        wait (pending_count == 0);
        repeat (60) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("integer_operator_alu_tb: clean");
        else
            $display("integer_operator_alu_tb: errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("integer_operator_alu_tb: errors");
        $finish;
    end
endmodule
